### src/tcw_pkg.sv
// shared types and constants of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int TCW_COLUMNS = 80;
  localparam int TCW_ROWS    = 25;

  localparam logic [7:0]  TCW_ATTR_RST  = 8'd23;
  localparam logic [7:0]  TCW_FILL_RST  = 8'd32;
  localparam logic [15:0] TCW_BLANK_RST = {TCW_ATTR_RST, TCW_FILL_RST};
  localparam logic [7:0]  TCW_NEWLINE   = 8'd10;

  typedef enum logic [2:0] {
    ACT_PRINT = 3'd0,
    ACT_MOVE  = 3'd1,
    ACT_CLEAR = 3'd2,
    ACT_PUT   = 3'd3,
    ACT_READ  = 3'd4
  } tcw_action_e;

  typedef enum logic [0:0] {
    CFG_TEXT_ATTR = 1'b0,
    CFG_FILL_CHAR = 1'b1
  } tcw_cfg_idx_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_code;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] cell_attr;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } tcw_out_t;

endpackage

### src/tcw_text_ram.sv
// text cell memory, one write port and one registered read port
`timescale 1ns / 1ps

module tcw_text_ram import tcw_pkg::*; #(
  parameter int DEPTH = TCW_COLUMNS * TCW_ROWS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [15:0]       wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/text_console_writer.sv
// text console writer: cursor sequencer, shared address unit and output register
// print, move and put pass an execute state and a response state; read adds a memory read state
// clear and a print that scrolls sweep the whole memory, then drain, before the response
// one word at a time, the next taken as the result is offered; the sweep sets the slow cases
// after reset a clearing pass writes the blank cell to all COLUMNS*ROWS cells;
// config writes are taken, input words are not
`timescale 1ns / 1ps

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  tcw_in_t      in_word_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output tcw_out_t     out_word_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  tcw_cfg_idx_e cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int SHIFT_N = COLUMNS * (ROWS - 1);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SWEEP,
    S_DRAIN,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } sweep_e;

  state_e state_q;
  sweep_e sweep_q;

  logic [7:0]        attr_q;
  logic [7:0]        fill_q;
  logic [2:0]        act_q;
  logic [7:0]        ch_q;
  logic [7:0]        cattr_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  cur_col_q;
  logic [ROW_W-1:0]  cur_row_q;
  logic [ADDR_W-1:0] idx_q;
  logic              pend_vld_q;
  logic              pend_blank_q;
  logic [ADDR_W-1:0] pend_addr_q;
  logic [15:0]       value_q;
  logic              scrolled_q;
  logic              out_valid_q;
  tcw_out_t          out_q;

  logic [COL_W-1:0]  col_clamp;
  logic [ROW_W-1:0]  row_clamp;
  logic [COL_W-1:0]  col_sel;
  logic [ROW_W-1:0]  row_sel;
  logic [ADDR_W-1:0] pos_addr;
  logic              blank_now;
  logic              sweep_last;
  logic              print_store;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;
  logic [15:0]       blank_cell;
  logic              out_free;

  assign col_clamp = (32'(in_word_i.col) > 32'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                             : COL_W'(in_word_i.col);
  assign row_clamp = (32'(in_word_i.row) > 32'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                          : ROW_W'(in_word_i.row);

  // shared address unit: cursor position for print, item position otherwise
  assign col_sel  = (act_q == ACT_PRINT) ? cur_col_q : col_q;
  assign row_sel  = (act_q == ACT_PRINT) ? cur_row_q : row_q;
  assign pos_addr = ADDR_W'(int'(row_sel) * COLUMNS + int'(col_sel));

  assign blank_now   = (sweep_q != SW_SCROLL) || (int'(idx_q) >= SHIFT_N);
  assign sweep_last  = (int'(idx_q) == CELLS - 1);
  assign print_store = (act_q == ACT_PRINT) && (ch_q != TCW_NEWLINE);
  assign blank_cell  = (sweep_q == SW_INIT) ? TCW_BLANK_RST : {attr_q, fill_q};

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = pos_addr;
    if (state_q == S_SWEEP) begin
      ram_re    = !blank_now;
      ram_raddr = ADDR_W'(int'(idx_q) + COLUMNS);
    end else if (state_q == S_EXEC && act_q == ACT_READ) begin
      ram_re = 1'b1;
    end
  end

  // sweep writes come in the cycle after their read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_addr;
    ram_wdata = {cattr_q, ch_q};
    if (pend_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = pend_blank_q ? blank_cell : ram_rdata;
    end else if (state_q == S_EXEC) begin
      ram_we = print_store || (act_q == ACT_PUT);
      if (act_q == ACT_PRINT) begin
        ram_wdata = {attr_q, ch_q};
      end
    end
  end

  tcw_text_ram #(
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      sweep_q      <= SW_INIT;
      attr_q       <= TCW_ATTR_RST;
      fill_q       <= TCW_FILL_RST;
      act_q        <= '0;
      ch_q         <= '0;
      cattr_q      <= '0;
      col_q        <= '0;
      row_q        <= '0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      idx_q        <= '0;
      pend_vld_q   <= 1'b0;
      pend_blank_q <= 1'b0;
      pend_addr_q  <= '0;
      value_q      <= '0;
      scrolled_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TEXT_ATTR: attr_q <= cfg_data_i;
          CFG_FILL_CHAR: fill_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end

      pend_vld_q <= (state_q == S_SWEEP);

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q      <= in_word_i.action;
            ch_q       <= in_word_i.char_code;
            cattr_q    <= in_word_i.cell_attr;
            col_q      <= col_clamp;
            row_q      <= row_clamp;
            value_q    <= '0;
            scrolled_q <= 1'b0;
            state_q    <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (act_q)
            ACT_PRINT: begin
              if (!print_store || int'(cur_col_q) == COLUMNS - 1) begin
                cur_col_q <= '0;
                if (int'(cur_row_q) == ROWS - 1) begin
                  // line advance past the bottom: scroll, cursor stays on last row
                  scrolled_q <= 1'b1;
                  sweep_q    <= SW_SCROLL;
                  idx_q      <= '0;
                  state_q    <= S_SWEEP;
                end else begin
                  cur_row_q <= cur_row_q + ROW_W'(1);
                  state_q   <= S_RESP;
                end
              end else begin
                cur_col_q <= cur_col_q + COL_W'(1);
                state_q   <= S_RESP;
              end
            end
            ACT_MOVE: begin
              cur_col_q <= col_q;
              cur_row_q <= row_q;
              state_q   <= S_RESP;
            end
            ACT_CLEAR: begin
              sweep_q <= SW_CLEAR;
              idx_q   <= '0;
              state_q <= S_SWEEP;
            end
            ACT_READ: begin
              state_q <= S_READ;
            end
            default: state_q <= S_RESP;
          endcase
        end
        S_READ: begin
          value_q <= ram_rdata;
          state_q <= S_RESP;
        end
        S_SWEEP: begin
          pend_blank_q <= blank_now;
          pend_addr_q  <= idx_q;
          if (sweep_last) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          state_q <= (sweep_q == SW_INIT) ? S_IDLE : S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_q.cell_value <= value_q;
            out_q.cursor_col <= 7'(cur_col_q);
            out_q.cursor_row <= 5'(cur_row_q);
            out_q.scrolled   <= scrolled_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(cur_col_q) <= COLUMNS - 1) && (int'(cur_row_q) <= ROWS - 1))
    else $error("cursor out of range");

  a_pend_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (state_q == S_SWEEP || state_q == S_DRAIN))
    else $error("sweep write outside sweep");

  a_word_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result word without response state");

  a_scroll_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.scrolled) |-> out_word_o.cursor_row == 5'(ROWS - 1))
    else $error("scroll left cursor off last row");

endmodule
